// ===== hdl/ptt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

	// Command codes of the input beat
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LIST   = 2'd2
	} cmd_t;

	// Status codes of the result beat
	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_LISTED    = 3'd3,
		ST_NONE      = 3'd4
	} status_t;

	// One table slot
	typedef struct packed {
		logic [31:0] key;
		logic [7:0]  prio;
		logic [31:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Operation of the shared compare unit
	typedef enum logic {
		CMP_KEY_EQ  = 1'b0,
		CMP_PRIO_GE = 1'b1
	} cmp_mode_t;

endpackage

`default_nettype wire

// ===== hdl/ptt_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Command channel
interface ptt_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] task_key;
	logic [7:0]  task_priority;
	logic [7:0]  list_min_prio;

	modport source (output valid, command, task_key, task_priority, list_min_prio,
		input ready);
	modport sink (input valid, command, task_key, task_priority, list_min_prio,
		output ready);
endinterface

// Result channel
interface ptt_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] out_key;
	logic [7:0]  out_priority;
	logic [31:0] out_stamp;
	logic        last;

	modport source (output valid, status, out_key, out_priority, out_stamp, last,
		input ready);
	modport sink (input valid, status, out_key, out_priority, out_stamp, last,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/ptt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port
module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/ptt_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared compare unit: key match or priority at/above a threshold
module ptt_cmp
	import ptt_pkg::*;
(
	input  wire cmp_mode_t mode,
	input  wire entry_t    ent,
	input  wire [31:0]     key,
	input  wire [7:0]      thr,
	output logic           hit
);

	always_comb begin
		unique case (mode)
			CMP_KEY_EQ:  hit = (ent.key == key);
			CMP_PRIO_GE: hit = (ent.prio >= thr);
			default:     hit = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_task_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded task table kept in descending priority order, ties in arrival order.
// Each command beat runs to completion before the next is taken; cmd.ready is
// high only while idle. The table lives in one RAM with one read and one write
// port, and every step reads one slot, waits for the registered read data and
// feeds it to a single compare unit. Insert walks from the tail and moves each
// lower-priority entry up one slot on the way. Remove scans for the key and
// then closes the gap. List scans every entry and waits whenever the result
// side stalls. Results leave through an output register, so the block runs on
// while one result waits to be taken.
module sorted_priority_task_table
	import ptt_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input wire clk,
	input wire arst_n,
	ptt_cmd_if.sink   cmd,
	ptt_res_if.source res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_RD,
		S_REM_CHK,
		S_REM_RD,
		S_SHF_CHK,
		S_SHF_RD,
		S_LST_CHK,
		S_LST_RD,
		S_LST_END,
		S_RESP
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [31:0]   arrival_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   key_q;
	logic [7:0]    thr_q;
	status_t       rsp_q;
	logic          pend_q;
	entry_t        pend_ent_q;

	logic          ovld_q;
	logic [2:0]    ostatus_q;
	logic [31:0]   okey_q;
	logic [7:0]    oprio_q;
	logic [31:0]   ostamp_q;
	logic          olast_q;

	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic [AW-1:0] raddr;
	logic [ENTRY_W-1:0] rdata;
	entry_t        rent;
	entry_t        new_ent;
	logic [CW-1:0] idx_dec;
	logic [CW-1:0] idx_inc;
	cmp_mode_t     cmp_mode;
	logic          hit;
	logic          out_free;
	logic          emit;

	assign idx_dec  = idx_q - CW'(1);
	assign idx_inc  = idx_q + CW'(1);
	assign rent     = entry_t'(rdata);
	assign out_free = !ovld_q || res.ready;
	assign new_ent  = '{key: key_q, prio: thr_q, stamp: arrival_q};
	assign cmp_mode = (state_q == S_REM_RD) ? CMP_KEY_EQ : CMP_PRIO_GE;

	// A result beat is loaded into the output register this cycle
	assign emit = out_free && ((state_q == S_LST_RD && hit && pend_q) ||
		state_q == S_LST_END || state_q == S_RESP);

	assign cmd.ready = (state_q == S_IDLE);

	assign res.valid        = ovld_q;
	assign res.status       = ostatus_q;
	assign res.out_key      = okey_q;
	assign res.out_priority = oprio_q;
	assign res.out_stamp    = ostamp_q;
	assign res.last         = olast_q;

	ptt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	ptt_cmp u_cmp (
		.mode (cmp_mode),
		.ent  (rent),
		.key  (key_q),
		.thr  (thr_q),
		.hit  (hit)
	);

	// Read address: one below the write slot on insert, one above on shift-down
	always_comb begin
		case (state_q)
			S_INS_CHK, S_INS_RD: raddr = idx_dec[AW-1:0];
			S_SHF_CHK, S_SHF_RD: raddr = idx_inc[AW-1:0];
			default:             raddr = idx_q[AW-1:0];
		endcase
	end

	// Write port
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rent;
		unique case (state_q)
			S_INS_CHK: begin
				if (idx_q == '0) begin
					we    = 1'b1;
					wdata = new_ent;
				end
			end
			S_INS_RD: begin
				we    = 1'b1;
				wdata = hit ? new_ent : rent;
			end
			S_SHF_RD: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			arrival_q <= '0;
			pend_q    <= 1'b0;
			ovld_q    <= 1'b0;
		end else begin
			if (emit) begin
				ovld_q <= 1'b1;
			end else if (res.ready) begin
				ovld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						key_q  <= cmd.task_key;
						pend_q <= 1'b0;
						case (cmd.command)
							CMD_INSERT: begin
								thr_q <= cmd.task_priority;
								idx_q <= count_q;
								if (count_q >= CAP_C) begin
									rsp_q   <= ST_FULL;
									state_q <= S_RESP;
								end else begin
									state_q <= S_INS_CHK;
								end
							end
							CMD_REMOVE: begin
								idx_q   <= '0;
								state_q <= S_REM_CHK;
							end
							CMD_LIST: begin
								thr_q   <= cmd.list_min_prio;
								idx_q   <= '0;
								state_q <= S_LST_CHK;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_INS_CHK: begin
					if (idx_q == '0) begin
						count_q   <= count_q + CW'(1);
						arrival_q <= arrival_q + 32'd1;
						rsp_q     <= ST_DONE;
						state_q   <= S_RESP;
					end else begin
						state_q <= S_INS_RD;
					end
				end
				S_INS_RD: begin
					if (hit) begin
						count_q   <= count_q + CW'(1);
						arrival_q <= arrival_q + 32'd1;
						rsp_q     <= ST_DONE;
						state_q   <= S_RESP;
					end else begin
						idx_q   <= idx_dec;
						state_q <= S_INS_CHK;
					end
				end
				S_REM_CHK: begin
					if (idx_q == count_q) begin
						rsp_q   <= ST_NOT_FOUND;
						state_q <= S_RESP;
					end else begin
						state_q <= S_REM_RD;
					end
				end
				S_REM_RD: begin
					if (hit) begin
						state_q <= S_SHF_CHK;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_REM_CHK;
					end
				end
				S_SHF_CHK: begin
					if (idx_inc == count_q) begin
						count_q <= count_q - CW'(1);
						rsp_q   <= ST_DONE;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SHF_RD;
					end
				end
				S_SHF_RD: begin
					idx_q   <= idx_inc;
					state_q <= S_SHF_CHK;
				end
				S_LST_CHK: begin
					state_q <= (idx_q == count_q) ? S_LST_END : S_LST_RD;
				end
				S_LST_RD: begin
					// A match is held back one step so the final one can carry last
					if (!hit) begin
						idx_q   <= idx_inc;
						state_q <= S_LST_CHK;
					end else if (!pend_q) begin
						pend_q     <= 1'b1;
						pend_ent_q <= rent;
						idx_q      <= idx_inc;
						state_q    <= S_LST_CHK;
					end else if (out_free) begin
						ostatus_q  <= ST_LISTED;
						okey_q     <= pend_ent_q.key;
						oprio_q    <= pend_ent_q.prio;
						ostamp_q   <= pend_ent_q.stamp;
						olast_q    <= 1'b0;
						pend_ent_q <= rent;
						idx_q      <= idx_inc;
						state_q    <= S_LST_CHK;
					end
				end
				S_LST_END: begin
					if (out_free) begin
						olast_q <= 1'b1;
						if (pend_q) begin
							ostatus_q <= ST_LISTED;
							okey_q    <= pend_ent_q.key;
							oprio_q   <= pend_ent_q.prio;
							ostamp_q  <= pend_ent_q.stamp;
						end else begin
							ostatus_q <= ST_NONE;
							okey_q    <= '0;
							oprio_q   <= '0;
							ostamp_q  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (out_free) begin
						ostatus_q <= rsp_q;
						okey_q    <= '0;
						oprio_q   <= '0;
						ostamp_q  <= '0;
						olast_q   <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
